/* sv/olid_pkg.sv */
// shared types and constants for the ordered list unit
// no dependencies; used by olid_ctrl, olid_dpath and the top level
package olid_pkg;

    localparam int OP_W       = 2;
    localparam int POS_W      = 8;
    localparam int VALUE_W    = 32;
    localparam int CNT_W      = 8;
    // cells per group in the registered match tree
    localparam int GROUP_SIZE = 8;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_FIND   = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MARK,
        ST_GROUP,
        ST_PICK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic mark;
        logic group;
        logic pick;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic out_full;
    } sts_t;

endpackage

/* sv/olid_ctrl.sv */
// controller state machine for the ordered list unit
// depends on olid_pkg; drives olid_dpath through cmd_t and reads sts_t
module olid_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic             m_tready,
    input  olid_pkg::sts_t   sts,
    output olid_pkg::cmd_t   cmd
);

    olid_pkg::state_t state_reg;
    olid_pkg::state_t state_next;
    logic             slot_free;

    assign slot_free = !sts.out_full || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= olid_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            olid_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = olid_pkg::ST_MARK;
                end
            end
            olid_pkg::ST_MARK:  state_next = olid_pkg::ST_GROUP;
            olid_pkg::ST_GROUP: state_next = olid_pkg::ST_PICK;
            olid_pkg::ST_PICK:  state_next = olid_pkg::ST_DONE;
            olid_pkg::ST_DONE:
            begin
                // hold until the output register can take the result
                if (slot_free)
                begin
                    state_next = olid_pkg::ST_IDLE;
                end
            end
            default: state_next = olid_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            olid_pkg::ST_IDLE:
            begin
                // no input beat is taken while reset is held
                s_tready = rst_n;
                cmd.load = s_tvalid && rst_n;
            end
            olid_pkg::ST_MARK:  cmd.mark  = 1'b1;
            olid_pkg::ST_GROUP: cmd.group = 1'b1;
            olid_pkg::ST_PICK:  cmd.pick  = 1'b1;
            olid_pkg::ST_DONE:  cmd.commit = slot_free;
            default:
            begin
                cmd      = '0;
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

/* sv/olid_dpath.sv */
// datapath for the ordered list unit: row of shifting cells, length count,
// two-level registered match tree and the output register; depends on olid_pkg
module olid_dpath
#(
    parameter int DEPTH     = 128,
    parameter int WORD_BITS = 32
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  olid_pkg::cmd_t                       cmd,
    output olid_pkg::sts_t                       sts,
    input  logic [olid_pkg::OP_W-1:0]            in_op,
    input  logic [olid_pkg::POS_W-1:0]           in_pos,
    input  logic signed [olid_pkg::VALUE_W-1:0]  in_value,
    input  logic                                 m_tready,
    output logic                                 out_valid,
    output logic                                 out_ok,
    output logic signed [olid_pkg::VALUE_W-1:0]  out_removed,
    output logic [olid_pkg::POS_W-1:0]           out_found,
    output logic [olid_pkg::CNT_W-1:0]           out_count
);

    localparam int GS     = olid_pkg::GROUP_SIZE;
    localparam int NGRP   = (DEPTH + GS - 1) / GS;
    localparam int PDEPTH = NGRP * GS;
    localparam int PIDX_W = $clog2(PDEPTH);
    localparam int LOC_W  = $clog2(GS);
    localparam int LEN_W  = $clog2(DEPTH + 1);

    // item registers
    logic [olid_pkg::OP_W-1:0]  op_reg;
    logic [olid_pkg::POS_W-1:0] pos_reg;
    logic [WORD_BITS-1:0]       word_reg;
    logic signed [63:0]         v_ext;

    // list state
    logic [LEN_W-1:0]           len_reg;
    logic [LEN_W-1:0]           len_next;
    logic [WORD_BITS-1:0]       cell_reg [DEPTH];
    logic [WORD_BITS-1:0]       cellp [PDEPTH];
    logic [WORD_BITS-1:0]       lower_w [DEPTH];
    logic [WORD_BITS-1:0]       upper_w [DEPTH];

    // match tree
    logic [PDEPTH-1:0]          flag_reg;
    logic [PDEPTH-1:0]          flag_next;
    logic [NGRP-1:0]            grp_hit_reg;
    logic [NGRP-1:0]            grp_hit_next;
    logic [LOC_W-1:0]           grp_loc_reg [NGRP];
    logic [LOC_W-1:0]           grp_loc_next [NGRP];
    logic [WORD_BITS-1:0]       grp_word_reg [NGRP];
    logic [WORD_BITS-1:0]       grp_word_next [NGRP];
    logic                       sel_hit_reg;
    logic                       sel_hit_next;
    logic [PIDX_W-1:0]          sel_idx_reg;
    logic [PIDX_W-1:0]          sel_idx_next;
    logic [WORD_BITS-1:0]       sel_word_reg;
    logic [WORD_BITS-1:0]       sel_word_next;

    // result
    logic                       ins_ok;
    logic                       del_ok;
    logic                       find_ok;
    logic signed [63:0]         r_ext;
    int                         p_idx;
    logic                       out_valid_reg;
    logic                       ok_reg;
    logic signed [olid_pkg::VALUE_W-1:0] removed_reg;
    logic [olid_pkg::POS_W-1:0] found_reg;
    logic [olid_pkg::CNT_W-1:0] count_reg;

    assign v_ext = 64'(in_value);

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            cellp[i] = cell_reg[i];
        end
        for (int i = DEPTH; i < PDEPTH; i++)
        begin
            cellp[i] = '0;
        end
    end

    // neighbor views for the shift up and shift down paths
    always_comb
    begin
        lower_w[0]       = '0;
        upper_w[DEPTH-1] = '0;
        for (int i = 1; i < DEPTH; i++)
        begin
            lower_w[i]   = cell_reg[i-1];
            upper_w[i-1] = cell_reg[i];
        end
    end

    // mark: one flag per cell, match for find or position hit for delete
    always_comb
    begin
        for (int i = 0; i < PDEPTH; i++)
        begin
            if (op_reg == olid_pkg::OP_DELETE)
            begin
                flag_next[i] = (i < int'(len_reg)) && (i == int'(pos_reg) - 1);
            end
            else
            begin
                flag_next[i] = (i < int'(len_reg)) && (cellp[i] == word_reg);
            end
        end
    end

    // first flagged cell inside each group
    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_hit_next[g]  = 1'b0;
            grp_loc_next[g]  = '0;
            grp_word_next[g] = '0;
            for (int j = GS - 1; j >= 0; j--)
            begin
                if (flag_reg[g*GS + j])
                begin
                    grp_hit_next[g]  = 1'b1;
                    grp_loc_next[g]  = LOC_W'(j);
                    grp_word_next[g] = cellp[g*GS + j];
                end
            end
        end
    end

    // first group with a hit
    always_comb
    begin
        sel_hit_next  = 1'b0;
        sel_idx_next  = '0;
        sel_word_next = '0;
        for (int g = NGRP - 1; g >= 0; g--)
        begin
            if (grp_hit_reg[g])
            begin
                sel_hit_next  = 1'b1;
                sel_idx_next  = PIDX_W'(g*GS + int'(grp_loc_reg[g]));
                sel_word_next = grp_word_reg[g];
            end
        end
    end

    // commit decisions
    always_comb
    begin
        p_idx   = int'(pos_reg) - 1;
        ins_ok  = (op_reg == olid_pkg::OP_INSERT) && (pos_reg != '0) &&
                  (int'(pos_reg) <= int'(len_reg) + 1) && (int'(len_reg) < DEPTH);
        del_ok  = (op_reg == olid_pkg::OP_DELETE) && (pos_reg != '0) &&
                  (int'(pos_reg) <= int'(len_reg));
        find_ok = (op_reg == olid_pkg::OP_FIND) && sel_hit_reg;
        r_ext   = 64'(signed'(sel_word_reg));
        priority if (ins_ok)
        begin
            len_next = len_reg + LEN_W'(1);
        end
        else if (del_ok)
        begin
            len_next = len_reg - LEN_W'(1);
        end
        else
        begin
            len_next = len_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= in_op;
            pos_reg  <= in_pos;
            word_reg <= v_ext[WORD_BITS-1:0];
        end
        if (cmd.mark)
        begin
            flag_reg <= flag_next;
        end
        if (cmd.group)
        begin
            grp_hit_reg  <= grp_hit_next;
            grp_loc_reg  <= grp_loc_next;
            grp_word_reg <= grp_word_next;
        end
        if (cmd.pick)
        begin
            sel_hit_reg  <= sel_hit_next;
            sel_idx_reg  <= sel_idx_next;
            sel_word_reg <= sel_word_next;
        end
        if (cmd.commit)
        begin
            ok_reg      <= ins_ok || del_ok || find_ok;
            removed_reg <= del_ok ? r_ext[olid_pkg::VALUE_W-1:0] : '0;
            found_reg   <= find_ok ? olid_pkg::POS_W'(int'(sel_idx_reg) + 1) : '0;
            count_reg   <= olid_pkg::CNT_W'(len_next);
        end
    end

    // all cells update together on commit; cells below the position keep their word
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                priority if (ins_ok && i > p_idx)
                begin
                    cell_reg[i] <= lower_w[i];
                end
                else if (ins_ok && i == p_idx)
                begin
                    cell_reg[i] <= word_reg;
                end
                else if (del_ok && i >= p_idx)
                begin
                    cell_reg[i] <= upper_w[i];
                end
                else
                begin
                    cell_reg[i] <= cell_reg[i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                len_reg       <= len_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.out_full = out_valid_reg;
    assign out_valid    = out_valid_reg;
    assign out_ok       = ok_reg;
    assign out_removed  = removed_reg;
    assign out_found    = found_reg;
    assign out_count    = count_reg;

endmodule

/* sv/ordered_list_insert_delete_find_unit.sv */
// channel  dir  tdata (low bit up)                        tuser
// s        in   position[7:0], value[39:8]                op[1:0]
// m        out  removed_value[31:0], found_at[39:32],     ok[0]
//               count[47:40]
//
// an item passes through the steps accept, mark all cells, group pick, group select and
// commit; commit loads its result into the output register, waiting while that register is full and not taken
// the mark and pick steps come from the two-level registered match tree over the cells
// reset clears the length count and holds s_tready low; cell contents stay undefined
// a result waiting in the output register does not block the next input beat;
// only the commit of the following item waits for the register to empty
//
// top level of the ordered list unit; depends on olid_pkg, olid_ctrl, olid_dpath
module ordered_list_insert_delete_find_unit
#(
    parameter int DEPTH     = 128,
    parameter int WORD_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // position[7:0], value[39:8]
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // removed_value[31:0], found_at[39:32], count[47:40]
    output logic        m_tuser    // ok[0]
);

    olid_pkg::cmd_t                          cmd;
    olid_pkg::sts_t                          sts;
    logic signed [olid_pkg::VALUE_W-1:0]     removed_value;
    logic [olid_pkg::POS_W-1:0]              found_at;
    logic [olid_pkg::CNT_W-1:0]              count;

    olid_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    olid_dpath
    #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    )
    u_dpath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_op       (s_tuser),
        .in_pos      (s_tdata[7:0]),
        .in_value    (signed'(s_tdata[39:8])),
        .m_tready    (m_tready),
        .out_valid   (m_tvalid),
        .out_ok      (m_tuser),
        .out_removed (removed_value),
        .out_found   (found_at),
        .out_count   (count)
    );

    assign m_tdata = {count, found_at, removed_value};

endmodule

/* sv/olid_check.sv */
// port-level checks for the ordered list unit, bound to the top level
// depends only on the top level's ports
module olid_check
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser
);

    // a waiting result beat holds still
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // one item at a time: busy right after an input beat
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in progress");

    // a failed operation carries no removed word and no position
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[39:0] == 40'd0)
        else $error("failed result carries payload");

    // a find hit never reports a removed word
    a_find_no_removed: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[39:32] != 8'd0 |-> m_tuser && m_tdata[31:0] == 32'd0)
        else $error("find result mixed with delete result");

endmodule

bind ordered_list_insert_delete_find_unit olid_check u_check (.*);
